// File: rtl/uvs_pkg.sv
package uvs_pkg;

    localparam int CNT_W = 11;
    localparam int IDX_W = 21;
    localparam int POS_W = 16;
    localparam int TEX_W = 17;
    localparam int PH_W = 32;
    localparam int CW = 34;
    localparam int Q_W = PH_W + 1;

    localparam logic [CNT_W-1:0] MAX_DIVISIONS = CNT_W'(1024);
    localparam int CORDIC_ITERATIONS = 16;
    localparam int DIV_BITS_PER_STAGE = 2;
    localparam int DIV_STAGES = PH_W / DIV_BITS_PER_STAGE;
    localparam int TEX_FRAC = 16;
    localparam int LAT_FRAC = 31;
    localparam int LON_FRAC = 32;

    localparam logic [PH_W-1:0] QUARTER_TURN = 32'h4000_0000;
    localparam logic signed [CW-1:0] CORDIC_GAIN_START = 34'sd652032874;
    localparam logic signed [POS_W-1:0] ONE_Q14 = 16'sd16384;
    localparam logic [TEX_W-1:0] TEX_ONE = 17'h10000;

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;

    typedef struct packed {
        logic [CNT_W-1:0] i;
        logic [CNT_W-1:0] j;
        logic [CNT_W-1:0] lon_rem;
        logic [CNT_W-1:0] lat_rem;
        logic [Q_W-1:0]   lon_q;
        logic [Q_W-1:0]   lat_q;
        logic             lon_rnd;
        logic [PH_W-1:0]  lat_ph;
        logic             lat_rnd;
        logic [TEX_W-1:0] u_q;
        logic             u_rnd;
        logic [TEX_W-1:0] v_q;
        logic             v_rnd;
    } div_t;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } rot_t;

    typedef struct packed {
        logic [CNT_W-1:0] i;
        logic [CNT_W-1:0] j;
        logic [TEX_W-1:0] u;
        logic [TEX_W-1:0] v;
        logic [1:0]       qa;
        logic [1:0]       qb;
        rot_t             ra;
        rot_t             rb;
    } cor_t;

    typedef struct packed {
        logic [CNT_W-1:0]       i;
        logic [CNT_W-1:0]       j;
        logic [TEX_W-1:0]       u;
        logic [TEX_W-1:0]       v;
        logic signed [POS_W-1:0] cl;
        logic signed [POS_W-1:0] sl;
        logic signed [POS_W-1:0] cg;
        logic signed [POS_W-1:0] sg;
    } trig_t;

    typedef struct packed {
        logic                 lower;
        logic                 upper;
        logic [IDX_W-1:0]     bottom_next;
        logic [IDX_W-1:0]     bottom;
        logic [IDX_W-1:0]     top_next;
        logic [IDX_W-1:0]     top;
        logic [TEX_W-1:0]     v;
        logic [TEX_W-1:0]     u;
        logic signed [POS_W-1:0] z;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] x;
    } res_t;

    function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] r);
        logic [CNT_W-1:0] e;
        if (r == '0)
            e = CNT_W'(1);
        else if (r > MAX_DIVISIONS)
            e = MAX_DIVISIONS;
        else
            e = r;
        return e;
    endfunction

    function automatic logic round_up(input logic [CNT_W-1:0] rem, input logic [CNT_W-1:0] d);
        return ({1'b0, rem} + {2'b0, d[CNT_W-1:1]}) >= {1'b0, d};
    endfunction

    function automatic logic [CW-1:0] atan_turn(input int k);
        logic [31:0] a;
        case (k)
            0:       a = 32'h20000000;
            1:       a = 32'h12E4051E;
            2:       a = 32'h09FB385B;
            3:       a = 32'h051111D4;
            4:       a = 32'h028B0D43;
            5:       a = 32'h0145D7E1;
            6:       a = 32'h00A2F61E;
            7:       a = 32'h00517C55;
            8:       a = 32'h0028BE53;
            9:       a = 32'h00145F2F;
            10:      a = 32'h000A2F98;
            11:      a = 32'h000517CC;
            12:      a = 32'h00028BE6;
            13:      a = 32'h000145F3;
            14:      a = 32'h0000A2FA;
            15:      a = 32'h0000517D;
            16:      a = 32'h000028BE;
            17:      a = 32'h0000145F;
            18:      a = 32'h00000A30;
            19:      a = 32'h00000518;
            20:      a = 32'h0000028C;
            21:      a = 32'h00000146;
            22:      a = 32'h000000A3;
            23:      a = 32'h00000051;
            default: a = 32'h0;
        endcase
        return CW'(a);
    endfunction

    function automatic rot_t rot_step(input rot_t v, input int n);
        rot_t r;
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;
        dx = v.x >>> n;
        dy = v.y >>> n;
        if (!v.z[CW-1])
        begin
            r.x = v.x - dy;
            r.y = v.y + dx;
            r.z = v.z - $signed(atan_turn(n));
        end
        else
        begin
            r.x = v.x + dy;
            r.y = v.y - dx;
            r.z = v.z + $signed(atan_turn(n));
        end
        return r;
    endfunction

    function automatic logic signed [POS_W-1:0] sat_q14(input logic signed [CW-1:0] v);
        logic signed [POS_W-1:0] r;
        if (v > CW'(ONE_Q14))
            r = ONE_Q14;
        else if (v < -CW'(ONE_Q14))
            r = -ONE_Q14;
        else
            r = v[POS_W-1:0];
        return r;
    endfunction

    function automatic logic signed [POS_W-1:0] cordic_fix(input logic signed [CW-1:0] v);
        logic signed [CW-1:0] s;
        s = (v + 34'sd32768) >>> 16;
        return sat_q14(s);
    endfunction

endpackage

// File: rtl/uv_sphere_vertex_index_generator.sv
// An accepted request passes through the divide, CORDIC and output stages before its result reaches the master side.
// One request is accepted per cycle while s_tready is high; every stage stalls only when the stage after
// it holds data that cannot move, so bubbles are squeezed out during a stall.
// The divide pipeline (two quotient bits per stage) and the CORDIC (one
// iteration per stage) set the depth.
// Reset clears all valid bits and sets the counts to 32 longitudes and 16 latitudes.
module uv_sphere_vertex_index_generator (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [10:0]  cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    // lat_step [10:0], lon_step [21:11], zero fill [23:22]
    input  logic [23:0]  s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // pos_x, pos_y, pos_z, tex_u, tex_v, top_index, top_next_index,
    // bottom_index, bottom_next_index, upper_tri_valid, lower_tri_valid
    output logic [167:0] m_tdata
);
    import uvs_pkg::*;

    localparam logic REG_LON = 1'b0;

    logic [CNT_W-1:0] lon_reg;
    logic [CNT_W-1:0] lat_reg;
    logic [CNT_W-1:0] lon_cnt;
    logic [CNT_W-1:0] lat_cnt;

    logic  div_vld;
    logic  div_rdy;
    div_t  div_data;
    logic  cor_vld;
    logic  cor_rdy;
    trig_t cor_data;
    res_t  res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lon_reg <= CNT_W'(32);
            lat_reg <= CNT_W'(16);
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_LON)
                lon_reg <= cfg_data;
            else
                lat_reg <= cfg_data;
        end
    end

    assign lon_cnt = eff_count(lon_reg);
    assign lat_cnt = eff_count(lat_reg);

    uvs_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .lat_step  (s_tdata[10:0]),
        .lon_step  (s_tdata[21:11]),
        .lon_cnt   (lon_cnt),
        .lat_cnt   (lat_cnt),
        .out_valid (div_vld),
        .out_ready (div_rdy),
        .out_data  (div_data)
    );

    uvs_cordic u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (div_vld),
        .in_ready  (div_rdy),
        .in_data   (div_data),
        .out_valid (cor_vld),
        .out_ready (cor_rdy),
        .out_data  (cor_data)
    );

    uvs_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cor_vld),
        .in_ready  (cor_rdy),
        .in_data   (cor_data),
        .lon_cnt   (lon_cnt),
        .lat_cnt   (lat_cnt),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (res)
    );

    assign m_tdata = res;

endmodule

// File: rtl/uvs_div.sv
module uvs_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [uvs_pkg::CNT_W-1:0]  lat_step,
    input  logic [uvs_pkg::CNT_W-1:0]  lon_step,
    input  logic [uvs_pkg::CNT_W-1:0]  lon_cnt,
    input  logic [uvs_pkg::CNT_W-1:0]  lat_cnt,
    output logic                       out_valid,
    input  logic                       out_ready,
    output uvs_pkg::div_t              out_data
);
    import uvs_pkg::*;

    localparam int N = DIV_STAGES;

    logic [N:0] vld_reg;
    logic [N:0] rdy;
    div_t       st_reg [0:N];
    div_t       st_next [0:N];

    always_comb
    begin
        div_t t;
        t = '0;
        t.i = (lat_step > lat_cnt) ? lat_cnt : lat_step;
        t.j = (lon_step > lon_cnt) ? lon_cnt : lon_step;
        t.lon_q = Q_W'(t.j == lon_cnt);
        t.lat_q = Q_W'(t.i == lat_cnt);
        t.lon_rem = (t.j == lon_cnt) ? '0 : t.j;
        t.lat_rem = (t.i == lat_cnt) ? '0 : t.i;
        st_next[0] = t;
    end

    genvar k;
    generate
        for (k = 1; k <= N; k++)
        begin : g_step
            always_comb
            begin
                div_t t;
                logic [CNT_W:0] r2;
                t = st_reg[k-1];
                for (int b = 0; b < DIV_BITS_PER_STAGE; b++)
                begin
                    r2 = {t.lon_rem, 1'b0};
                    if (r2 >= {1'b0, lon_cnt})
                    begin
                        t.lon_rem = CNT_W'(r2 - {1'b0, lon_cnt});
                        t.lon_q = {t.lon_q[Q_W-2:0], 1'b1};
                    end
                    else
                    begin
                        t.lon_rem = r2[CNT_W-1:0];
                        t.lon_q = {t.lon_q[Q_W-2:0], 1'b0};
                    end
                    r2 = {t.lat_rem, 1'b0};
                    if (r2 >= {1'b0, lat_cnt})
                    begin
                        t.lat_rem = CNT_W'(r2 - {1'b0, lat_cnt});
                        t.lat_q = {t.lat_q[Q_W-2:0], 1'b1};
                    end
                    else
                    begin
                        t.lat_rem = r2[CNT_W-1:0];
                        t.lat_q = {t.lat_q[Q_W-2:0], 1'b0};
                    end
                    if ((k - 1) * DIV_BITS_PER_STAGE + b + 1 == TEX_FRAC)
                    begin
                        t.u_q = t.lon_q[TEX_W-1:0];
                        t.u_rnd = round_up(t.lon_rem, lon_cnt);
                        t.v_q = t.lat_q[TEX_W-1:0];
                        t.v_rnd = round_up(t.lat_rem, lat_cnt);
                    end
                    if ((k - 1) * DIV_BITS_PER_STAGE + b + 1 == LAT_FRAC)
                    begin
                        t.lat_ph = t.lat_q[PH_W-1:0];
                        t.lat_rnd = round_up(t.lat_rem, lat_cnt);
                    end
                    if ((k - 1) * DIV_BITS_PER_STAGE + b + 1 == LON_FRAC)
                        t.lon_rnd = round_up(t.lon_rem, lon_cnt);
                end
                st_next[k] = t;
            end
        end

        for (k = 0; k <= N; k++)
        begin : g_stage
            logic up_valid;
            if (k == N)
            begin : g_last
                assign rdy[k] = !vld_reg[k] || out_ready;
            end
            else
            begin : g_mid
                assign rdy[k] = !vld_reg[k] || rdy[k+1];
            end
            if (k == 0)
            begin : g_first
                assign up_valid = in_valid;
            end
            else
            begin : g_rest
                assign up_valid = vld_reg[k-1];
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_reg[k] <= 1'b0;
                else if (rdy[k])
                    vld_reg[k] <= up_valid;
            end

            always_ff @(posedge clk)
            begin
                if (rdy[k] && up_valid)
                    st_reg[k] <= st_next[k];
            end
        end
    endgenerate

    assign in_ready = rdy[0];
    assign out_valid = vld_reg[N];
    assign out_data = st_reg[N];

endmodule

// File: rtl/uvs_cordic.sv
module uvs_cordic (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  uvs_pkg::div_t  in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output uvs_pkg::trig_t out_data
);
    import uvs_pkg::*;

    localparam int N = CORDIC_ITERATIONS;

    logic [N+1:0] vld_reg;
    logic [N+1:0] rdy;
    cor_t         st_reg [0:N];
    cor_t         st_next [0:N];
    trig_t        fin_reg;
    trig_t        fin_next;

    always_comb
    begin
        cor_t t;
        logic [PH_W-1:0] lat_ph;
        logic [PH_W-1:0] lon_ph;
        lat_ph = QUARTER_TURN - (in_data.lat_ph + PH_W'(in_data.lat_rnd));
        lon_ph = in_data.lon_q[PH_W-1:0] + PH_W'(in_data.lon_rnd);
        t.i = in_data.i;
        t.j = in_data.j;
        t.u = in_data.u_q + TEX_W'(in_data.u_rnd);
        t.v = TEX_ONE - (in_data.v_q + TEX_W'(in_data.v_rnd));
        t.qa = lat_ph[PH_W-1:PH_W-2];
        t.qb = lon_ph[PH_W-1:PH_W-2];
        t.ra.x = CORDIC_GAIN_START;
        t.ra.y = '0;
        t.ra.z = $signed(CW'(lat_ph[PH_W-3:0]));
        t.rb.x = CORDIC_GAIN_START;
        t.rb.y = '0;
        t.rb.z = $signed(CW'(lon_ph[PH_W-3:0]));
        st_next[0] = t;
    end

    genvar k;
    generate
        for (k = 1; k <= N; k++)
        begin : g_iter
            always_comb
            begin
                cor_t t;
                t = st_reg[k-1];
                t.ra = rot_step(t.ra, k - 1);
                t.rb = rot_step(t.rb, k - 1);
                st_next[k] = t;
            end
        end
    endgenerate

    always_comb
    begin
        logic signed [POS_W-1:0] ca;
        logic signed [POS_W-1:0] sa;
        logic signed [POS_W-1:0] cb;
        logic signed [POS_W-1:0] sb;
        ca = cordic_fix(st_reg[N].ra.x);
        sa = cordic_fix(st_reg[N].ra.y);
        cb = cordic_fix(st_reg[N].rb.x);
        sb = cordic_fix(st_reg[N].rb.y);
        fin_next.i = st_reg[N].i;
        fin_next.j = st_reg[N].j;
        fin_next.u = st_reg[N].u;
        fin_next.v = st_reg[N].v;
        case (st_reg[N].qa)
            QUAD_0:  begin fin_next.cl = ca;  fin_next.sl = sa;  end
            QUAD_1:  begin fin_next.cl = -sa; fin_next.sl = ca;  end
            QUAD_2:  begin fin_next.cl = -ca; fin_next.sl = -sa; end
            default: begin fin_next.cl = sa;  fin_next.sl = -ca; end
        endcase
        case (st_reg[N].qb)
            QUAD_0:  begin fin_next.cg = cb;  fin_next.sg = sb;  end
            QUAD_1:  begin fin_next.cg = -sb; fin_next.sg = cb;  end
            QUAD_2:  begin fin_next.cg = -cb; fin_next.sg = -sb; end
            default: begin fin_next.cg = sb;  fin_next.sg = -cb; end
        endcase
    end

    generate
        for (k = 0; k <= N + 1; k++)
        begin : g_stage
            logic up_valid;
            if (k == N + 1)
            begin : g_last
                assign rdy[k] = !vld_reg[k] || out_ready;
            end
            else
            begin : g_mid
                assign rdy[k] = !vld_reg[k] || rdy[k+1];
            end
            if (k == 0)
            begin : g_first
                assign up_valid = in_valid;
            end
            else
            begin : g_rest
                assign up_valid = vld_reg[k-1];
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_reg[k] <= 1'b0;
                else if (rdy[k])
                    vld_reg[k] <= up_valid;
            end

            if (k <= N)
            begin : g_data
                always_ff @(posedge clk)
                begin
                    if (rdy[k] && up_valid)
                        st_reg[k] <= st_next[k];
                end
            end
            else
            begin : g_fin
                always_ff @(posedge clk)
                begin
                    if (rdy[k] && up_valid)
                        fin_reg <= fin_next;
                end
            end
        end
    endgenerate

    assign in_ready = rdy[0];
    assign out_valid = vld_reg[N+1];
    assign out_data = fin_reg;

endmodule

// File: rtl/uvs_out.sv
module uvs_out (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  uvs_pkg::trig_t             in_data,
    input  logic [uvs_pkg::CNT_W-1:0]  lon_cnt,
    input  logic [uvs_pkg::CNT_W-1:0]  lat_cnt,
    output logic                       out_valid,
    input  logic                       out_ready,
    output uvs_pkg::res_t              out_data
);
    import uvs_pkg::*;

    typedef struct packed {
        logic signed [2*POS_W-1:0] px;
        logic signed [2*POS_W-1:0] pz;
        logic signed [POS_W-1:0]   sl;
        logic [TEX_W-1:0]          u;
        logic [TEX_W-1:0]          v;
        logic [IDX_W-1:0]          base;
        logic [CNT_W-1:0]          j;
        logic                      upper;
        logic                      lower;
    } mul_t;

    logic  mul_vld_reg;
    logic  res_vld_reg;
    logic  mul_rdy;
    logic  res_rdy;
    mul_t  mul_reg;
    mul_t  mul_next;
    res_t  res_reg;
    res_t  res_next;

    always_comb
    begin
        logic in_grid;
        in_grid = (in_data.i < lat_cnt) && (in_data.j < lon_cnt);
        mul_next.px = in_data.cl * in_data.cg;
        mul_next.pz = in_data.cl * in_data.sg;
        mul_next.sl = in_data.sl;
        mul_next.u = in_data.u;
        mul_next.v = in_data.v;
        mul_next.base = IDX_W'(in_data.i) * (IDX_W'(lon_cnt) + IDX_W'(1));
        mul_next.j = in_data.j;
        mul_next.upper = in_grid && (in_data.i != '0);
        mul_next.lower = in_grid && (in_data.i != lat_cnt - CNT_W'(1));
    end

    always_comb
    begin
        logic [IDX_W-1:0] top;
        logic [IDX_W-1:0] bottom;
        top = mul_reg.base + IDX_W'(mul_reg.j);
        bottom = top + IDX_W'(lon_cnt) + IDX_W'(1);
        res_next.x = sat_q14((CW'(mul_reg.px) + 34'sd8192) >>> 14);
        res_next.z = sat_q14((CW'(mul_reg.pz) + 34'sd8192) >>> 14);
        res_next.y = mul_reg.sl;
        res_next.u = mul_reg.u;
        res_next.v = mul_reg.v;
        res_next.top = top;
        res_next.top_next = top + IDX_W'(1);
        res_next.bottom = bottom;
        res_next.bottom_next = bottom + IDX_W'(1);
        res_next.upper = mul_reg.upper;
        res_next.lower = mul_reg.lower;
    end

    assign res_rdy = !res_vld_reg || out_ready;
    assign mul_rdy = !mul_vld_reg || res_rdy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_vld_reg <= 1'b0;
            res_vld_reg <= 1'b0;
        end
        else
        begin
            if (mul_rdy)
                mul_vld_reg <= in_valid;
            if (res_rdy)
                res_vld_reg <= mul_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mul_rdy && in_valid)
            mul_reg <= mul_next;
        if (res_rdy && mul_vld_reg)
            res_reg <= res_next;
    end

    assign in_ready = mul_rdy;
    assign out_valid = res_vld_reg;
    assign out_data = res_reg;

endmodule

// File: rtl/uvs_checker.sv
module uvs_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [167:0] m_tdata
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("Stalled result changed.");

    a_top_next: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[123:103] == m_tdata[102:82] + 21'd1)
        else $error("Top next index is not top index plus one.");

    a_bottom_next: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[165:145] == m_tdata[144:124] + 21'd1)
        else $error("Bottom next index is not bottom index plus one.");

    a_row_gap: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[166] || m_tdata[167]) |->
            m_tdata[144:124] >= m_tdata[102:82] + 21'd2)
        else $error("Bottom index of a valid cell is too close to its top index.");

endmodule

bind uv_sphere_vertex_index_generator uvs_checker u_uvs_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
